>>> hw/rtl/cir_pkg.sv
// ----------------------------------------------------------------------------
// cir_pkg
// Shared types and constants of the contact impulse resolver.
// ----------------------------------------------------------------------------
package cir_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int FRAC_MAX      = 24;
  localparam int UXW           = FRAC_MAX + 2;
  localparam int QUEUE_DEPTH   = 4;

  localparam logic [16:0] CORR_RESET = 17'd13107;
  localparam logic [22:0] SLOP_RESET = 23'd655;

  typedef enum logic {
    CFG_CORRECTION = 1'b0,
    CFG_SLOP       = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [16:0] correction_percent;
    logic [22:0] penetration_slop;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] mtv_x;
    logic signed [31:0] mtv_y;
    logic signed [31:0] vel1_x;
    logic signed [31:0] vel1_y;
    logic signed [31:0] vel2_x;
    logic signed [31:0] vel2_y;
    logic        [30:0] inv_mass1;
    logic        [30:0] inv_mass2;
    logic        [16:0] restitution1;
    logic        [16:0] restitution2;
  } pair_t;

  typedef struct packed {
    logic               contact;
    logic               impulse_applied;
    logic signed [31:0] new_vel1_x;
    logic signed [31:0] new_vel1_y;
    logic signed [31:0] new_vel2_x;
    logic signed [31:0] new_vel2_y;
    logic signed [31:0] shift1_x;
    logic signed [31:0] shift1_y;
    logic signed [31:0] shift2_x;
    logic signed [31:0] shift2_y;
  } result_t;

  // normalized contact handed from front to back
  typedef struct packed {
    logic                  contact;
    logic        [31:0]    mag;
    logic signed [UXW-1:0] ux;
    logic signed [UXW-1:0] uy;
    pair_t                 pair;
  } fb_t;

endpackage

>>> hw/rtl/cir_div.sv
// ----------------------------------------------------------------------------
// cir_div
// Pipelined restoring divider, one quotient bit per stage, with side tag.
// The numerator must be below den * 2^QW.
// ----------------------------------------------------------------------------
module cir_div #(
  parameter int NW = 48,
  parameter int DW = 32,
  parameter int QW = 17,
  parameter int TW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [TW-1:0] in_tag,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          out_valid,
  output logic [TW-1:0] out_tag,
  output logic [QW-1:0] quo
);
  localparam int CW = (NW > DW + QW) ? NW : DW + QW;

  logic [QW:0]   vld;
  logic [NW-1:0] rem [0:QW];
  logic [DW-1:0] dd  [0:QW];
  logic [QW-1:0] qq  [0:QW];
  logic [TW-1:0] tg  [0:QW];
  logic [NW-1:0] rem_next [1:QW];
  logic [QW:1]   bit_next;

  always_comb begin
    for (int j = 1; j <= QW; j++) begin
      bit_next[j] = CW'(rem[j-1]) >= (CW'(dd[j-1]) << (QW - j));
      rem_next[j] = bit_next[j] ?
                    NW'(CW'(rem[j-1]) - (CW'(dd[j-1]) << (QW - j))) : rem[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[QW-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= num;
      dd[0]  <= den;
      qq[0]  <= '0;
      tg[0]  <= in_tag;
      for (int j = 1; j <= QW; j++) begin
        rem[j] <= rem_next[j];
        dd[j]  <= dd[j-1];
        qq[j]  <= {qq[j-1][QW-2:0], bit_next[j]};
        tg[j]  <= tg[j-1];
      end
    end
  end

  assign out_valid = vld[QW];
  assign out_tag   = tg[QW];
  assign quo       = qq[QW];

endmodule

>>> hw/rtl/cir_sqrt.sv
// ----------------------------------------------------------------------------
// cir_sqrt
// Pipelined integer square root (floor), one root bit per stage, with side tag.
// ----------------------------------------------------------------------------
module cir_sqrt #(
  parameter int W  = 64,
  parameter int TW = 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  logic [TW-1:0]  in_tag,
  input  logic [W-1:0]   rad,
  output logic           out_valid,
  output logic [TW-1:0]  out_tag,
  output logic [W/2-1:0] root
);
  localparam int N = W / 2;

  logic [N:0]    vld;
  logic [W-1:0]  vv [0:N];
  logic [W-1:0]  rr [0:N];
  logic [TW-1:0] tg [0:N];
  logic [W-1:0]  vv_next [1:N];
  logic [W-1:0]  rr_next [1:N];
  logic [W-1:0]  rb      [1:N];

  always_comb begin
    for (int j = 1; j <= N; j++) begin
      rb[j] = rr[j-1] + (W'(1) << (W - 2 * j));
      if (vv[j-1] >= rb[j]) begin
        vv_next[j] = vv[j-1] - rb[j];
        rr_next[j] = (rr[j-1] >> 1) + (W'(1) << (W - 2 * j));
      end else begin
        vv_next[j] = vv[j-1];
        rr_next[j] = rr[j-1] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[N-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vv[0] <= rad;
      rr[0] <= '0;
      tg[0] <= in_tag;
      for (int j = 1; j <= N; j++) begin
        vv[j] <= vv_next[j];
        rr[j] <= rr_next[j];
        tg[j] <= tg[j-1];
      end
    end
  end

  assign out_valid = vld[N];
  assign out_tag   = tg[N];
  assign root      = rr[N][N-1:0];

endmodule

>>> hw/rtl/cir_queue.sv
// ----------------------------------------------------------------------------
// cir_queue
// Short register queue between the front and back pipelines.
// ----------------------------------------------------------------------------
module cir_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0] mem [0:DEPTH-1];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;
  logic          do_push;
  logic          do_pop;

  assign full    = count == (AW+1)'(DEPTH);
  assign empty   = count == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (AW+1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

>>> hw/rtl/cir_front.sv
// ----------------------------------------------------------------------------
// cir_front
// Front pipeline: contact test, vector length and unit normal.
// ----------------------------------------------------------------------------
module cir_front #(
  parameter int FRAC_BITS = cir_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  cir_pkg::pair_t pair,
  input  logic          q_full,
  output logic          q_push,
  output cir_pkg::fb_t  fb_word
);
  import cir_pkg::*;

  localparam int F  = FRAC_BITS;
  localparam int NW = 32 + F;
  localparam int QW = F + 1;

  function automatic logic [31:0] abs32(logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  logic        en;
  logic        s0_valid;
  pair_t       s0_pair;
  logic        s1_valid;
  pair_t       s1_pair;
  logic [63:0] sq_x;
  logic [63:0] sq_y;
  logic        rt_valid;
  pair_t       rt_pair;
  logic [31:0] root;
  logic        dx_valid;
  logic        dy_valid;
  pair_t       dx_pair;
  logic [31:0] dy_mag;
  logic [QW-1:0] qx;
  logic [QW-1:0] qy;
  logic signed [UXW-1:0] ux_mag;
  logic signed [UXW-1:0] uy_mag;
  logic        fb_valid;
  fb_t         fb_next;

  assign en     = !(fb_valid && q_full);
  assign full   = !en;
  assign q_push = fb_valid && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
      fb_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= push;
      s1_valid <= s0_valid;
      fb_valid <= dx_valid && dy_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_pair <= pair;
      s1_pair <= s0_pair;
      sq_x    <= 64'(abs32(s0_pair.mtv_x)) * 64'(abs32(s0_pair.mtv_x));
      sq_y    <= 64'(abs32(s0_pair.mtv_y)) * 64'(abs32(s0_pair.mtv_y));
      fb_word <= fb_next;
    end
  end

  cir_sqrt #(.W(64), .TW($bits(pair_t))) u_sqrt (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(s1_valid), .in_tag(s1_pair), .rad(sq_x + sq_y),
    .out_valid(rt_valid), .out_tag(rt_pair), .root(root)
  );

  cir_div #(.NW(NW), .DW(32), .QW(QW), .TW($bits(pair_t))) u_div_x (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(rt_valid), .in_tag(rt_pair),
    .num({abs32(rt_pair.mtv_x), {F{1'b0}}}), .den(root),
    .out_valid(dx_valid), .out_tag(dx_pair), .quo(qx)
  );

  cir_div #(.NW(NW), .DW(32), .QW(QW), .TW(32)) u_div_y (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(rt_valid), .in_tag(root),
    .num({abs32(rt_pair.mtv_y), {F{1'b0}}}), .den(root),
    .out_valid(dy_valid), .out_tag(dy_mag), .quo(qy)
  );

  always_comb begin
    ux_mag          = {{(UXW-QW){1'b0}}, qx};
    uy_mag          = {{(UXW-QW){1'b0}}, qy};
    fb_next.contact = (dx_pair.mtv_x != '0) || (dx_pair.mtv_y != '0);
    fb_next.mag     = dy_mag;
    fb_next.ux      = dx_pair.mtv_x[31] ? -ux_mag : ux_mag;
    fb_next.uy      = dx_pair.mtv_y[31] ? -uy_mag : uy_mag;
    fb_next.pair    = dx_pair;
  end

endmodule

>>> hw/rtl/cir_back.sv
// ----------------------------------------------------------------------------
// cir_back
// Back pipeline: normal velocity, impulse, velocity update and
// penetration correction, with the output register.
// ----------------------------------------------------------------------------
module cir_back #(
  parameter int FRAC_BITS = cir_pkg::FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  cir_pkg::cfg_t    cfg,
  input  logic             q_empty,
  input  cir_pkg::fb_t     q_word,
  output logic             q_pop,
  output logic             empty,
  input  logic             pop,
  output cir_pkg::result_t result
);
  import cir_pkg::*;

  localparam int F    = FRAC_BITS;
  localparam int UW   = F + 2;
  localparam int PW   = 33 + UW;
  localparam int VW   = PW + 1 - F;
  localparam int TPW  = VW + 19;
  localparam int TTW  = TPW - 16;
  localparam int KNW  = TTW + F;
  localparam int QNW  = 32 + F;
  localparam int KW   = 32 + UW;
  localparam int CMPW = (KNW > 63) ? KNW : 63;

  localparam logic signed [64:0] SAT_HI = 65'sd2147483647;
  localparam logic signed [64:0] SAT_LO = -65'sd2147483648;

  typedef struct packed {
    logic               contact;
    logic               live;
    logic               pos;
    logic               ksat;
    logic signed [31:0] v1x;
    logic signed [31:0] v1y;
    logic signed [31:0] v2x;
    logic signed [31:0] v2y;
    logic [30:0]        im1;
    logic [30:0]        im2;
    logic [31:0]        sum_im;
    logic [17:0]        rest_gain;
    logic [31:0]        excess;
    logic signed [UW-1:0]  ux;
    logic signed [UW-1:0]  uy;
    logic signed [32:0]    dvx;
    logic signed [32:0]    dvy;
    logic signed [PW-1:0]  px;
    logic signed [PW-1:0]  py;
    logic signed [VW-1:0]  van;
    logic signed [TPW-1:0] tp;
    logic signed [KW-1:0]  pkx;
    logic signed [KW-1:0]  pky;
    logic [47:0]           pm;
    logic signed [31:0]    ix;
    logic signed [31:0]    iy;
    logic [30:0]           m;
    logic signed [63:0]    p1x;
    logic signed [63:0]    p1y;
    logic signed [63:0]    p2x;
    logic signed [63:0]    p2y;
    logic signed [KW-1:0]  cmx;
    logic signed [KW-1:0]  cmy;
    logic signed [31:0]    nv1x;
    logic signed [31:0]    nv1y;
    logic signed [31:0]    nv2x;
    logic signed [31:0]    nv2y;
    logic signed [31:0]    cx;
    logic signed [31:0]    cy;
    logic signed [63:0]    t1x;
    logic signed [63:0]    t1y;
    logic signed [63:0]    t2x;
    logic signed [63:0]    t2y;
  } bk_t;

  function automatic logic signed [31:0] sat32(logic signed [64:0] v);
    if (v > SAT_HI) begin
      return 32'h7FFFFFFF;
    end else if (v < SAT_LO) begin
      return 32'h80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [64:0] ext64(logic signed [63:0] v);
    return {v[63], v};
  endfunction

  function automatic logic signed [64:0] ext32(logic signed [31:0] v);
    return {{33{v[31]}}, v};
  endfunction

  logic    en;
  logic    take;
  logic    out_full;
  result_t res_next;
  logic    va, vb, vc, vd, ve_k, ve_q, vf, vg, vh, vi, vj;
  bk_t     sa, sb, sc, sd, se, sf, sg, sh, si, sj;
  bk_t     na, nb, nc, nd, nf, ng, nh, ni, nj;
  logic [PW:0]       dot;
  logic [16:0]       rest_min;
  logic [32:0]       ex_diff;
  logic [TTW-1:0]    tt;
  logic [KNW-1:0]    kn;
  logic [QNW-1:0]    qn;
  logic              qsat_in;
  logic              qsat_out;
  logic [30:0]       quo_k;
  logic [30:0]       quo_q;
  logic [30:0]       kk;
  logic [30:0]       qq;
  logic signed [31:0] f2;

  assign take  = vj && (!out_full || pop);
  assign en    = !(vj && out_full && !pop);
  assign q_pop = !q_empty && en;
  assign empty = !out_full;

  // stage a: sums, differences, restitution
  always_comb begin
    na           = '0;
    rest_min     = (q_word.pair.restitution1 < q_word.pair.restitution2) ?
                   q_word.pair.restitution1 : q_word.pair.restitution2;
    ex_diff      = {1'b0, q_word.mag} - {10'b0, cfg.penetration_slop};
    na.contact   = q_word.contact;
    na.v1x       = q_word.pair.vel1_x;
    na.v1y       = q_word.pair.vel1_y;
    na.v2x       = q_word.pair.vel2_x;
    na.v2y       = q_word.pair.vel2_y;
    na.im1       = q_word.pair.inv_mass1;
    na.im2       = q_word.pair.inv_mass2;
    na.sum_im    = {1'b0, q_word.pair.inv_mass1} + {1'b0, q_word.pair.inv_mass2};
    na.live      = q_word.contact && (na.sum_im != '0);
    na.rest_gain = 18'd65536 + {1'b0, rest_min};
    na.excess    = ex_diff[32] ? '0 : ex_diff[31:0];
    na.ux        = q_word.ux[UW-1:0];
    na.uy        = q_word.uy[UW-1:0];
    na.dvx       = $signed({q_word.pair.vel2_x[31], q_word.pair.vel2_x})
                 - $signed({q_word.pair.vel1_x[31], q_word.pair.vel1_x});
    na.dvy       = $signed({q_word.pair.vel2_y[31], q_word.pair.vel2_y})
                 - $signed({q_word.pair.vel1_y[31], q_word.pair.vel1_y});
  end

  always_comb begin
    nb    = sa;
    nb.px = PW'($signed(sa.dvx)) * PW'($signed(sa.ux));
    nb.py = PW'($signed(sa.dvy)) * PW'($signed(sa.uy));
  end

  always_comb begin
    nc     = sb;
    dot    = $signed({sb.px[PW-1], sb.px}) + $signed({sb.py[PW-1], sb.py});
    nc.van = VW'($signed(dot) >>> F);
    nc.pos = sb.live && !nc.van[VW-1] && (nc.van != '0);
  end

  always_comb begin
    nd    = sc;
    nd.tp = $signed(TPW'({1'b0, sc.rest_gain})) * TPW'($signed(sc.van));
  end

  // divider operands, saturated quotients bypass the dividers
  always_comb begin
    tt       = sd.pos ? TTW'($signed(sd.tp) >>> 16) : '0;
    kn       = {tt, {F{1'b0}}};
    qn       = {sd.excess, {F{1'b0}}};
    nf       = sd;
    nf.ksat  = CMPW'(kn) >= CMPW'({sd.sum_im, 31'b0});
    qsat_in  = 63'(qn) >= {sd.sum_im, 31'b0};
  end

  cir_div #(.NW(KNW), .DW(32), .QW(31), .TW($bits(bk_t))) u_div_k (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(vd), .in_tag(nf), .num(nf.ksat ? '0 : kn), .den(sd.sum_im),
    .out_valid(ve_k), .out_tag(se), .quo(quo_k)
  );

  cir_div #(.NW(QNW), .DW(32), .QW(31), .TW(1)) u_div_q (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(vd), .in_tag(qsat_in), .num(qsat_in ? '0 : qn), .den(sd.sum_im),
    .out_valid(ve_q), .out_tag(qsat_out), .quo(quo_q)
  );

  always_comb begin
    kk = se.ksat ? 31'h7FFFFFFF : quo_k;
    qq = qsat_out ? 31'h7FFFFFFF : quo_q;
  end

  // stage f: impulse and correction magnitudes
  bk_t nf2;
  always_comb begin
    nf2     = se;
    nf2.pkx = $signed(KW'({1'b0, kk})) * KW'($signed(se.ux));
    nf2.pky = $signed(KW'({1'b0, kk})) * KW'($signed(se.uy));
    nf2.pm  = 48'(qq) * 48'(cfg.correction_percent);
  end

  always_comb begin
    ng    = sf;
    ng.ix = 32'((-$signed(sf.pkx)) >>> F);
    ng.iy = 32'((-$signed(sf.pky)) >>> F);
    ng.m  = sf.pm[47] ? 31'h7FFFFFFF : sf.pm[46:16];
  end

  always_comb begin
    nh     = sg;
    nh.p1x = $signed(64'({1'b0, sg.im1})) * 64'($signed(sg.ix));
    nh.p1y = $signed(64'({1'b0, sg.im1})) * 64'($signed(sg.iy));
    nh.p2x = $signed(64'({1'b0, sg.im2})) * 64'($signed(sg.ix));
    nh.p2y = $signed(64'({1'b0, sg.im2})) * 64'($signed(sg.iy));
    nh.cmx = $signed(KW'({1'b0, sg.m})) * KW'($signed(sg.ux));
    nh.cmy = $signed(KW'({1'b0, sg.m})) * KW'($signed(sg.uy));
  end

  always_comb begin
    ni      = sh;
    ni.nv1x = sat32(ext32(sh.v1x) - ext64($signed(sh.p1x) >>> F));
    ni.nv1y = sat32(ext32(sh.v1y) - ext64($signed(sh.p1y) >>> F));
    ni.nv2x = sat32(ext32(sh.v2x) + ext64($signed(sh.p2x) >>> F));
    ni.nv2y = sat32(ext32(sh.v2y) + ext64($signed(sh.p2y) >>> F));
    ni.cx   = 32'($signed(sh.cmx) >>> F);
    ni.cy   = 32'($signed(sh.cmy) >>> F);
  end

  // body 1 always scales by its own mass; body 2 flips sign when both move
  always_comb begin
    nj     = si;
    f2     = (si.im1 == '0) ? $signed({1'b0, si.im2}) : -$signed({1'b0, si.im2});
    nj.t1x = 64'($signed(si.cx)) * 64'($signed({1'b0, si.im1}));
    nj.t1y = 64'($signed(si.cy)) * 64'($signed({1'b0, si.im1}));
    nj.t2x = 64'($signed(si.cx)) * 64'(f2);
    nj.t2y = 64'($signed(si.cy)) * 64'(f2);
  end

  always_comb begin
    res_next.contact         = sj.contact;
    res_next.impulse_applied = sj.pos;
    res_next.new_vel1_x      = sj.pos ? sj.nv1x : sj.v1x;
    res_next.new_vel1_y      = sj.pos ? sj.nv1y : sj.v1y;
    res_next.new_vel2_x      = sj.pos ? sj.nv2x : sj.v2x;
    res_next.new_vel2_y      = sj.pos ? sj.nv2y : sj.v2y;
    res_next.shift1_x        = sj.live ? sat32(ext64($signed(sj.t1x) >>> F)) : '0;
    res_next.shift1_y        = sj.live ? sat32(ext64($signed(sj.t1y) >>> F)) : '0;
    res_next.shift2_x        = sj.live ? sat32(ext64($signed(sj.t2x) >>> F)) : '0;
    res_next.shift2_y        = sj.live ? sat32(ext64($signed(sj.t2y) >>> F)) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0; vb <= 1'b0; vc <= 1'b0; vd <= 1'b0;
      vf <= 1'b0; vg <= 1'b0; vh <= 1'b0; vi <= 1'b0; vj <= 1'b0;
    end else if (en) begin
      va <= q_pop;
      vb <= va;
      vc <= vb;
      vd <= vc;
      vf <= ve_k && ve_q;
      vg <= vf;
      vh <= vg;
      vi <= vh;
      vj <= vi;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa <= na;
      sb <= nb;
      sc <= nc;
      sd <= nd;
      sf <= nf2;
      sg <= ng;
      sh <= nh;
      si <= ni;
      sj <= nj;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (take) begin
      out_full <= 1'b1;
    end else if (pop) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result <= res_next;
    end
  end

endmodule

>>> hw/rtl/contact_impulse_resolver.sv
// ----------------------------------------------------------------------------
// contact_impulse_resolver
// Impulse-based collision response for one 2D body pair per word.
//
// Input side is a queue: a pair word is taken when push is high and full is
// low. Result side is a queue too: the oldest result sits on result while
// empty is low and leaves when pop is high. Registers are written through
// cfg_valid/cfg_ready (always ready), cfg_index selects the register and
// cfg_data carries the value; write only while no word is in flight.
// One word per cycle is taken and delivered in steady state while results are
// popped. The path from push to empty low runs through the square root
// pipeline (33 stages), the normal divider (FRAC_BITS + 2 stages) and the
// impulse divider (32 stages).
// When the result is not popped, the back pipeline holds, its input queue
// fills, then the front pipeline holds and full goes high; nothing is lost.
// Reset empties all pipelines and queues and loads correction_percent = 0.2
// and penetration_slop = 0.01.
// ----------------------------------------------------------------------------
module contact_impulse_resolver #(
  parameter int FRAC_BITS = cir_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  cir_pkg::pair_t      pair,
  output logic                empty,
  input  logic                pop,
  output cir_pkg::result_t    result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  cir_pkg::cfg_index_t cfg_index,
  input  logic [22:0]         cfg_data
);
  import cir_pkg::*;

  cfg_t cfg;
  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  fb_t  fb_word;
  fb_t  q_word;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.correction_percent <= CORR_RESET;
      cfg.penetration_slop   <= SLOP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CORRECTION: cfg.correction_percent <= cfg_data[16:0];
        CFG_SLOP:       cfg.penetration_slop   <= cfg_data;
        default:        cfg <= cfg;
      endcase
    end
  end

  cir_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .pair(pair),
    .q_full(q_full), .q_push(q_push), .fb_word(fb_word)
  );

  cir_queue #(.W($bits(fb_t)), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst(rst),
    .push(q_push), .wdata(fb_word), .full(q_full),
    .pop(q_pop), .rdata(q_word), .empty(q_empty)
  );

  cir_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst(rst), .cfg(cfg),
    .q_empty(q_empty), .q_word(q_word), .q_pop(q_pop),
    .empty(empty), .pop(pop), .result(result)
  );

endmodule
